// ===== src/positional_list_engine_assert.svh =====
// assertion macros for the list engine
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define PLE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define PLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);
`else
`define PLE_ASSERT(lbl, clk, rstn, prop, msg)
`define PLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== src/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// request codes, status codes and shared types of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam logic [3:0] MODE_INS_FRONT = 4'd0;
	localparam logic [3:0] MODE_INS_BACK  = 4'd1;
	localparam logic [3:0] MODE_INS_AT    = 4'd2;
	localparam logic [3:0] MODE_DEL_FRONT = 4'd3;
	localparam logic [3:0] MODE_DEL_BACK  = 4'd4;
	localparam logic [3:0] MODE_DEL_AT    = 4'd5;
	localparam logic [3:0] MODE_READ      = 4'd6;
	localparam logic [3:0] MODE_FIND      = 4'd7;
	localparam logic [3:0] MODE_CLEAR     = 4'd8;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_INDEX = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	// cells per reduction group
	localparam int GROUP_SIZE = 8;
	localparam int LOC_W      = 3;

	// broadcast command to every cell of the chain
	typedef struct packed {
		logic ins;
		logic del;
		logic rd;
		logic fnd;
	} cell_cmd_t;

endpackage

// ===== src/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// one list position: holds a word, shifts with its neighbours, compares
// ----------------------------------------------------------------------------
module ple_cell #(
	parameter int POS        = 0,
	parameter int CW         = 6,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  ple_pkg::cell_cmd_t    cmd,
	input  logic [CW-1:0]         pos,
	input  logic [CW-1:0]         count,
	input  logic [DATA_WIDTH-1:0] new_word,
	input  logic [DATA_WIDTH-1:0] prev_word,
	input  logic [DATA_WIDTH-1:0] next_word,
	output logic [DATA_WIDTH-1:0] word,
	output logic                  match_s1,
	output logic [DATA_WIDTH-1:0] rd_data_s1
);

	localparam logic [CW-1:0] MY_POS = CW'(POS);

	logic [DATA_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		// insert opens a gap at pos, delete closes it
		if (cmd.ins && (MY_POS >= pos)) begin
			word_q <= (MY_POS == pos) ? new_word : prev_word;
		end else if (cmd.del && (MY_POS >= pos)) begin
			word_q <= next_word;
		end
		match_s1   <= cmd.fnd && (MY_POS < count) && (word_q == new_word);
		rd_data_s1 <= (cmd.rd && (MY_POS == pos)) ? word_q : '0;
	end

	assign word = word_q;

endmodule

// ===== src/ple_group.sv =====
// ----------------------------------------------------------------------------
// ple_group
// first-match encode and read-data merge over one group of cells
// ----------------------------------------------------------------------------
module ple_group #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                                             clk,
	input  logic [ple_pkg::GROUP_SIZE-1:0]                   match,
	input  logic [ple_pkg::GROUP_SIZE-1:0][DATA_WIDTH-1:0]   rd_data,
	output logic                                             any_s2,
	output logic [ple_pkg::LOC_W-1:0]                        loc_s2,
	output logic [DATA_WIDTH-1:0]                            data_s2
);

	logic [ple_pkg::LOC_W-1:0] loc;
	logic [DATA_WIDTH-1:0]     data;

	always_comb begin
		loc  = '0;
		data = '0;
		// lowest matching cell wins
		for (int i = ple_pkg::GROUP_SIZE - 1; i >= 0; i--) begin
			if (match[i]) begin
				loc = ple_pkg::LOC_W'(i);
			end
		end
		for (int i = 0; i < ple_pkg::GROUP_SIZE; i++) begin
			data = data | rd_data[i];
		end
	end

	always_ff @(posedge clk) begin
		any_s2  <= |match;
		loc_s2  <= loc;
		data_s2 <= data;
	end

endmodule

// ===== src/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// bounded ordered list with clear, find by value, and insert, delete and read at a position
// ----------------------------------------------------------------------------
// channel   direction  handshake          fields
// request   in         start, busy        mode, index, value
// result    out        done (one cycle)   status, read_value, found_index,
//                                         entry_count
//
// a request is taken on any cycle start is high; busy stays low
// the result strobes done once the request has passed valid_s1 and valid_s2
// insert and delete shift the cell chain at the accepting edge, read and
// find go through per-cell compare, group encode and a final pick stage
// reset clears the entry count and the valid pipeline with done; stored words are undefined until written
// the receiver cannot stall, so results are never held back
// ----------------------------------------------------------------------------
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
	parameter int LIST_DEPTH = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         mode,
	input  logic [5:0]         index,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [31:0] read_value,
	output logic [4:0]         found_index,
	output logic [5:0]         entry_count
);

	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int IW = (CW > 6) ? CW : 6;
	localparam int GS = ple_pkg::GROUP_SIZE;
	localparam int NG = (LIST_DEPTH + GS - 1) / GS;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic [CW-1:0]         pos;
	logic [2:0]            status_pre;
	ple_pkg::cell_cmd_t    cmd;
	logic                  accept;
	logic [IW-1:0]         idx_x;
	logic [IW-1:0]         cnt_x;
	logic                  empty;
	logic                  full;
	logic signed [63:0]    value_ext;
	logic [DATA_WIDTH-1:0] new_word;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign idx_x     = IW'(index);
	assign cnt_x     = IW'(count_q);
	assign empty     = (count_q == '0);
	assign full      = (count_q == FULL_CNT);
	assign value_ext = 64'(value);
	assign new_word  = value_ext[DATA_WIDTH-1:0];

	always_comb begin
		cmd        = '0;
		pos        = '0;
		status_pre = ple_pkg::ST_OK;
		count_d    = count_q;
		unique case (mode)
			ple_pkg::MODE_INS_FRONT, ple_pkg::MODE_INS_BACK: begin
				pos = (mode == ple_pkg::MODE_INS_FRONT) ? '0 : count_q;
				if (full) begin
					status_pre = ple_pkg::ST_FULL;
				end else begin
					cmd.ins = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			ple_pkg::MODE_INS_AT: begin
				pos = CW'(index);
				if (idx_x > cnt_x) begin
					status_pre = ple_pkg::ST_BAD_INDEX;
				end else if (full) begin
					status_pre = ple_pkg::ST_FULL;
				end else begin
					cmd.ins = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			ple_pkg::MODE_DEL_FRONT, ple_pkg::MODE_DEL_BACK: begin
				pos = (mode == ple_pkg::MODE_DEL_FRONT) ? '0 : count_q - 1'b1;
				if (empty) begin
					status_pre = ple_pkg::ST_EMPTY;
				end else begin
					cmd.del = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			ple_pkg::MODE_DEL_AT, ple_pkg::MODE_READ: begin
				pos = CW'(index);
				if (empty) begin
					status_pre = ple_pkg::ST_EMPTY;
				end else if (idx_x >= cnt_x) begin
					status_pre = ple_pkg::ST_BAD_INDEX;
				end else if (mode == ple_pkg::MODE_READ) begin
					cmd.rd = 1'b1;
				end else begin
					cmd.del = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			ple_pkg::MODE_FIND: begin
				if (empty) begin
					status_pre = ple_pkg::ST_EMPTY;
				end else begin
					cmd.fnd = 1'b1;
				end
			end
			ple_pkg::MODE_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
		if (!accept) begin
			cmd     = '0;
			count_d = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// cell chain
	logic [LIST_DEPTH-1:0][DATA_WIDTH-1:0] words;
	logic [NG*GS-1:0]                      match_s1;
	logic [NG*GS-1:0][DATA_WIDTH-1:0]      rd_s1;

	for (genvar p = 0; p < LIST_DEPTH; p++) begin : g_cell
		ple_cell #(
			.POS        (p),
			.CW         (CW),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.pos        (pos),
			.count      (count_q),
			.new_word   (new_word),
			.prev_word  ((p == 0) ? new_word : words[(p == 0) ? 0 : p - 1]),
			.next_word  (words[(p == LIST_DEPTH - 1) ? p : p + 1]),
			.word       (words[p]),
			.match_s1   (match_s1[p]),
			.rd_data_s1 (rd_s1[p])
		);
	end

	for (genvar p = LIST_DEPTH; p < NG * GS; p++) begin : g_pad
		assign match_s1[p] = 1'b0;
		assign rd_s1[p]    = '0;
	end

	// group stage
	logic [NG-1:0]                     any_s2;
	logic [NG-1:0][ple_pkg::LOC_W-1:0] loc_s2;
	logic [NG-1:0][DATA_WIDTH-1:0]     data_s2;

	for (genvar g = 0; g < NG; g++) begin : g_grp
		ple_group #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_grp (
			.clk     (clk),
			.match   (match_s1[g*GS +: GS]),
			.rd_data (rd_s1[g*GS +: GS]),
			.any_s2  (any_s2[g]),
			.loc_s2  (loc_s2[g]),
			.data_s2 (data_s2[g])
		);
	end

	// sideband pipeline
	logic       valid_s1, valid_s2;
	logic [2:0] status_s1, status_s2;
	logic       rd_s1_q, rd_s2;
	logic       fnd_s1, fnd_s2;
	logic [CW-1:0] cnt_s1, cnt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			done     <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= status_pre;
		rd_s1_q   <= cmd.rd;
		fnd_s1    <= cmd.fnd;
		cnt_s1    <= count_d;
		status_s2 <= status_s1;
		rd_s2     <= rd_s1_q;
		fnd_s2    <= fnd_s1;
		cnt_s2    <= cnt_s1;
	end

	// final pick over groups
	logic                  any_f;
	logic [GW-1:0]         grp_f;
	logic [DATA_WIDTH-1:0] data_f;
	logic [GW+ple_pkg::LOC_W-1:0] found_pos;
	logic signed [63:0]    rd_ext;

	always_comb begin
		any_f  = 1'b0;
		grp_f  = '0;
		data_f = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (any_s2[g]) begin
				any_f = 1'b1;
				grp_f = GW'(g);
			end
		end
		for (int g = 0; g < NG; g++) begin
			data_f = data_f | data_s2[g];
		end
	end

	assign found_pos = {grp_f, loc_s2[grp_f]};
	assign rd_ext    = 64'($signed(data_f));

	always_ff @(posedge clk) begin
		entry_count <= 6'(cnt_s2);
		if (fnd_s2) begin
			status      <= any_f ? ple_pkg::ST_OK : ple_pkg::ST_NOT_FOUND;
			found_index <= any_f ? 5'(found_pos) : 5'd0;
		end else begin
			status      <= status_s2;
			found_index <= 5'd0;
		end
		read_value <= rd_s2 ? rd_ext[31:0] : '1;
	end

	`PLE_ASSERT_IMPL(a_latency, clk, arst_n, accept, ##3 done, "result strobe missing")
	`PLE_ASSERT_IMPL(a_no_spurious, clk, arst_n, done, $past(accept, 3), "result without request")
	`PLE_ASSERT(a_count_bound, clk, arst_n, count_q <= FULL_CNT, "entry count above depth")
	`PLE_ASSERT_IMPL(a_err_read, clk, arst_n, done && (status != ple_pkg::ST_OK), &read_value, "error result carries read data")
	`PLE_ASSERT_IMPL(a_found_ok, clk, arst_n, done && (found_index != 5'd0), status == ple_pkg::ST_OK, "found index on failed request")

endmodule
